// File: hdl/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared types and constants for the varint frame deframer: status codes,
// field widths and the result record handed to the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package vfd_pkg;

  localparam int unsigned MaxFrameBytesDef = 2048;
  localparam int unsigned MaxDigits        = 5;
  localparam int unsigned LenW             = 35;
  localparam int unsigned IdW              = 17;
  localparam int unsigned MsgIdW           = 16;
  localparam int unsigned PlenW            = 11;
  localparam int unsigned DigitW           = 7;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SMALL    = 3'd1,
    ST_LEN_TRUNC    = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_ID_TRUNC     = 3'd4,
    ST_OVERLONG     = 3'd5
  } status_e;

  typedef struct packed {
    logic               payload_valid;
    logic [7:0]         payload_byte;
    logic               done;
    status_e            status;
    logic [MsgIdW-1:0]  msg_id;
    logic [PlenW-1:0]   payload_length;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/vfd_parser.sv
// ----------------------------------------------------------------------------
// vfd_parser
// Per-byte frame state: length and identifier varint accumulation, byte
// count, and the summary computed on the frame's last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_parser import vfd_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_byte_i,
  output result_t         res_o,
  output logic            res_push_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 2);
  localparam int unsigned PW   = (CntW > PlenW) ? CntW : PlenW;
  localparam int unsigned SumW = LenW + 1;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_ID,
    PH_DATA,
    PH_SKIP
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        dc_q, dc_d;
  logic [2:0]        hb_q, hb_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [IdW-1:0]    id_q, id_d;
  logic              ovl_q, ovl_d;

  logic [5:0]        shamt;
  logic [LenW-1:0]   digit;
  logic              pv;
  status_e           status;
  logic [SumW-1:0]   len_sum;
  logic [PW-1:0]     plen_full;

  assign shamt = 6'd7 * {3'b000, dc_q};
  assign digit = LenW'(in_byte_i[DigitW-1:0]) << shamt;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = (cnt_q <= CntW'(MAX_FRAME_BYTES)) ? cnt_q + CntW'(1) : cnt_q;
    dc_d    = dc_q;
    hb_d    = hb_q;
    len_d   = len_q;
    id_d    = id_q;
    ovl_d   = ovl_q;
    pv      = 1'b0;
    unique case (phase_q)
      PH_LEN, PH_ID: begin
        if (dc_q >= 3'(MaxDigits)) begin
          ovl_d   = 1'b1;
          phase_d = PH_SKIP;
        end else begin
          if (phase_q == PH_LEN) begin
            len_d = len_q | digit;
          end else begin
            id_d = id_q | IdW'(digit);
          end
          dc_d = dc_q + 3'd1;
          if (!in_byte_i[7]) begin
            if (phase_q == PH_LEN) begin
              hb_d    = dc_q + 3'd1;
              dc_d    = 3'd0;
              phase_d = PH_ID;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        pv = 1'b1;
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
  end

  // summary for the last byte, from the updated state
  assign len_sum   = {1'b0, len_d} + SumW'(hb_d);
  assign plen_full = PW'(cnt_d) - PW'(hb_d) - PW'(dc_d);

  always_comb begin
    priority if (cnt_d < CntW'(2)) begin
      status = ST_TOO_SMALL;
    end else if (hb_d == 3'd0) begin
      status = ovl_d ? ST_OVERLONG : ST_LEN_TRUNC;
    end else if ((len_d == '0) || (cnt_d > CntW'(MAX_FRAME_BYTES)) ||
                 (len_sum != SumW'(cnt_d))) begin
      status = ST_LEN_MISMATCH;
    end else if (phase_d == PH_ID) begin
      status = ST_ID_TRUNC;
    end else if (phase_d == PH_SKIP) begin
      status = ST_OVERLONG;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_o.payload_valid  = pv;
    res_o.payload_byte   = pv ? in_byte_i : 8'd0;
    res_o.done           = last_byte_i;
    res_o.status         = last_byte_i ? status : ST_OK;
    res_o.msg_id         = (last_byte_i && status == ST_OK) ? id_d[MsgIdW:1] : '0;
    res_o.payload_length = (last_byte_i && status == ST_OK) ? plen_full[PlenW-1:0] : '0;
  end

  assign res_push_o = accept_i && (pv || last_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      cnt_q   <= '0;
      dc_q    <= '0;
      hb_q    <= '0;
      len_q   <= '0;
      id_q    <= '0;
      ovl_q   <= 1'b0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q <= PH_LEN;
        cnt_q   <= '0;
        dc_q    <= '0;
        hb_q    <= '0;
        len_q   <= '0;
        id_q    <= '0;
        ovl_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        dc_q    <= dc_d;
        hb_q    <= hb_d;
        len_q   <= len_d;
        id_q    <= id_d;
        ovl_q   <= ovl_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/vfd_out_buf.sv
// ----------------------------------------------------------------------------
// vfd_out_buf
// Two-entry output buffer: a result register plus a skid register, so a new
// request is taken while a finished result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module vfd_out_buf import vfd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  logic    main_v_q;
  logic    skid_v_q;
  result_t main_q;
  result_t skid_q;
  logic    pop;

  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;
  assign pop     = main_v_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        main_v_q <= push_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      if (main_v_q) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/varint_frame_deframer_unit.sv
// each result is registered in the output buffer before it is presented
// throughput: one byte per cycle; input stalls only when two results are held
// the parser state update is combinational logic; a two-entry output
// buffer decouples the request side from the result side
// reset clears the frame state and empties the output buffer; frame state
// also returns to its reset value after each last byte
// ----------------------------------------------------------------------------
// varint_frame_deframer_unit
// Parses a varint length, a varint identifier and streams payload bytes of
// one frame, giving a status summary on the frame's last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_frame_deframer_unit import vfd_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              last_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   payload_valid_o,
  output logic [7:0]             payload_byte_o,
  output logic                   done_res_o,
  output logic [2:0]             status_o,
  output logic [MsgIdW-1:0]      msg_id_o,
  output logic [PlenW-1:0]       payload_length_o
);

  logic    accept;
  logic    res_push;
  result_t res;
  result_t out_res;

  assign accept = in_valid_i && in_ready_o;

  vfd_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .last_byte_i(last_byte_i),
    .res_o      (res),
    .res_push_o (res_push)
  );

  vfd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_res)
  );

  assign payload_valid_o  = out_res.payload_valid;
  assign payload_byte_o   = out_res.payload_byte;
  assign done_res_o       = out_res.done;
  assign status_o         = out_res.status;
  assign msg_id_o         = out_res.msg_id;
  assign payload_length_o = out_res.payload_length;

  // every delivered result is either a payload byte or a frame summary
  a_no_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (payload_valid_o || done_res_o))
    else $error("empty result delivered");

  // failed frames report no identifier or length
  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o && status_o != ST_OK) |->
      (msg_id_o == '0 && payload_length_o == '0))
    else $error("fields set on failed frame");

  // status only on the summary
  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (status_o == ST_OK))
    else $error("status without done");

  // skid only fills when the result register is held
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("skid full with empty output");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (payload_byte_o == 8'd0))
    else $error("payload byte set without payload valid");

endmodule

`default_nettype wire

// File: test/varint_frame_deframer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_frame_deframer_unit_test
// Sends whole frames through the deframer, byte by byte with random gaps
// and output stalls. A directed table covers the error codes and the field
// extremes; random frames follow: mostly well formed, the rest with bad
// lengths, cut short, overlong fields or noise. Every result is checked
// against the directed table's typed rows or an in-bench frame parser.
// ----------------------------------------------------------------------------

module varint_frame_deframer_unit_test;
  import vfd_pkg::*;

  localparam int unsigned NumDirected   = 29;
  localparam int unsigned RandomItems   = 570;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxPrinted    = 50;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_IDENT   = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_SKIP    = 2'd3
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]        data;
    logic              lst;
    logic              typed;
    status_e           st;
    logic [MsgIdW-1:0] id;
    logic [PlenW-1:0]  plen;
  } stim_row_t;

  // typed rows carry the summary of a header-only last byte
  localparam stim_row_t DirectedRows [NumDirected] = '{
    // single byte frame
    '{8'h05, 1'b1, 1'b1, ST_TOO_SMALL,    16'h0000, 11'd0},
    // length field still open on the last byte
    '{8'h80, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h81, 1'b1, 1'b1, ST_LEN_TRUNC,    16'h0000, 11'd0},
    // shortest good frame, no payload
    '{8'h01, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h02, 1'b1, 1'b1, ST_OK,           16'h0001, 11'd0},
    // zero length
    '{8'h00, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h00, 1'b1, 1'b1, ST_LEN_MISMATCH, 16'h0000, 11'd0},
    // identifier still open on the last byte
    '{8'h02, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b1, 1'b1, ST_ID_TRUNC,     16'h0000, 11'd0},
    // sixth byte in the length field
    '{8'hff, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'hff, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'hff, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'hff, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'hff, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b1, 1'b1, ST_OVERLONG,     16'h0000, 11'd0},
    // sixth byte in the identifier field
    '{8'h06, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h80, 1'b1, 1'b1, ST_OVERLONG,     16'h0000, 11'd0},
    // all-ones identifier, payload 00 then ff
    '{8'h05, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'hff, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'hff, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h7f, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'h00, 1'b0, 1'b0, ST_OK,           16'h0000, 11'd0},
    '{8'hff, 1'b1, 1'b0, ST_OK,           16'h0000, 11'd0}
  };

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [7:0]        in_byte_i   = 8'h00;
  logic              last_byte_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              payload_valid_o;
  logic [7:0]        payload_byte_o;
  logic              done_res_o;
  logic [2:0]        status_o;
  logic [MsgIdW-1:0] msg_id_o;
  logic [PlenW-1:0]  payload_length_o;

  // in-bench copy of the frame parser state
  parse_phase_e frame_phase;
  logic [11:0]  frame_count;
  logic [2:0]   digit_idx;
  logic [63:0]  length_acc;
  logic [63:0]  ident_acc;
  logic [3:0]   header_len;
  status_e      frame_err;

  result_t     pending_results [$];
  logic [7:0]  frame_q [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned random_items   = 0;
  bit          tx_no_gap      = 1'b0;
  bit          rx_no_gap      = 1'b0;

  varint_frame_deframer_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_valid_o  (payload_valid_o),
    .payload_byte_o   (payload_byte_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .msg_id_o         (msg_id_o),
    .payload_length_o (payload_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_frame_state();
    frame_phase = PH_LENGTH;
    frame_count = '0;
    digit_idx   = '0;
    length_acc  = '0;
    ident_acc   = '0;
    header_len  = '0;
    frame_err   = ST_OK;
  endfunction

  // advances the parser by one byte; returns 1 when the byte yields a result
  function automatic bit parse_frame_byte(input logic [7:0] b, input logic lst,
                                          output result_t res);
    logic [11:0] cnt;
    logic        pv;
    logic [63:0] digit;
    status_e     st;
    res = '0;
    pv  = 1'b0;
    st  = ST_OK;
    cnt = frame_count;
    if (cnt <= MaxFrameBytesDef) cnt = cnt + 1'b1;
    frame_count = cnt;
    if (frame_phase == PH_LENGTH || frame_phase == PH_IDENT) begin
      if (digit_idx >= MaxDigits) begin
        frame_err   = ST_OVERLONG;
        frame_phase = PH_SKIP;
      end else begin
        digit = 64'(b[6:0]) << (7 * digit_idx);
        if (frame_phase == PH_LENGTH) length_acc = length_acc | digit;
        else ident_acc = ident_acc | digit;
        digit_idx = digit_idx + 1'b1;
        if (!b[7]) begin
          if (frame_phase == PH_LENGTH) begin
            header_len  = 4'(digit_idx);
            digit_idx   = '0;
            frame_phase = PH_IDENT;
          end else begin
            frame_phase = PH_PAYLOAD;
          end
        end
      end
    end else if (frame_phase == PH_PAYLOAD) begin
      pv = 1'b1;
    end
    if (!pv && !lst) return 1'b0;
    if (lst) begin
      if (cnt < 2) st = ST_TOO_SMALL;
      else if (header_len == 0) st = (frame_err == ST_OVERLONG) ? ST_OVERLONG : ST_LEN_TRUNC;
      else if (length_acc == 0 || cnt > MaxFrameBytesDef ||
               length_acc + 64'(header_len) != 64'(cnt)) st = ST_LEN_MISMATCH;
      else if (frame_phase == PH_IDENT) st = ST_ID_TRUNC;
      else if (frame_phase == PH_SKIP) st = ST_OVERLONG;
      if (st == ST_OK) begin
        res.msg_id         = ident_acc[MsgIdW:1];
        res.payload_length = PlenW'(cnt - 12'(header_len) - 12'(digit_idx));
      end
    end
    res.payload_valid = pv;
    res.payload_byte  = pv ? b : 8'h00;
    res.done          = lst;
    res.status        = st;
    if (lst) clear_frame_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MaxPrinted)
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input result_t typed_res);
    int unsigned gap;
    result_t     res;
    gap = tx_no_gap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_byte_i   <= b;
    last_byte_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    if (parse_frame_byte(b, lst, res) || typed) begin
      if (typed) pending_results = {pending_results, typed_res};
      else pending_results = {pending_results, res};
    end
  endtask

  // sender holds off until every outstanding result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  function automatic void add_varint(input logic [63:0] value, input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++)
      frame_q = {frame_q, {1'(i + 1 < nbytes), 7'(value >> (7 * i))}};
  endfunction

  function automatic void build_frame();
    logic [7:0]  body_q [$];
    int unsigned kind;
    int unsigned id_n;
    int unsigned pay_n;
    int unsigned len_n;
    int unsigned keep;
    logic [63:0] len_val;
    bit          overlong;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      repeat ($urandom_range(1, 10)) frame_q = {frame_q, 8'($urandom)};
      return;
    end
    overlong = (kind >= 86);
    id_n = $urandom_range(1, 3);
    if ($urandom_range(0, 7) == 0) id_n = $urandom_range(4, 5);
    if (overlong && $urandom_range(0, 1) == 1) id_n = $urandom_range(6, 8);
    for (int unsigned i = 0; i < id_n; i++)
      body_q = {body_q, {1'(i + 1 < id_n), 7'($urandom)}};
    pay_n = $urandom_range(0, 20);
    repeat (pay_n) body_q = {body_q, 8'($urandom)};
    len_val = 64'(body_q.size());
    if (kind >= 70 && kind < 78) begin
      if ($urandom_range(0, 3) == 0) len_val = '0;
      else if ($urandom_range(0, 1) == 1) len_val = len_val + $urandom_range(1, 3);
      else len_val = len_val - 1;
    end
    len_n = (len_val < 128) ? 1 : 2;
    if ($urandom_range(0, 4) == 0) len_n = $urandom_range(len_n, MaxDigits);
    if (overlong && id_n <= MaxDigits) len_n = $urandom_range(6, 7);
    add_varint(len_val, len_n);
    frame_q = {frame_q, body_q};
    if (kind >= 78 && kind < 86 && frame_q.size() > 1) begin
      keep = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
  endfunction

  task automatic send_frame();
    tx_no_gap = ($urandom_range(0, 3) == 0);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("varint_frame_deframer_unit_test failed");
    $finish;
  end

  // result side: random stalls, compare against the oldest expectation
  initial begin
    result_t     want;
    int unsigned stall;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_no_gap = !rx_no_gap;
      stall = rx_no_gap ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result",
                        32'({done_res_o, status_o, payload_byte_o}), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (payload_valid_o !== want.payload_valid)
          report_mismatch("payload_valid", 32'(payload_valid_o), 32'(want.payload_valid));
        if (payload_byte_o !== want.payload_byte)
          report_mismatch("payload_byte", 32'(payload_byte_o), 32'(want.payload_byte));
        if (done_res_o !== want.done)
          report_mismatch("done_res", 32'(done_res_o), 32'(want.done));
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (msg_id_o !== want.msg_id)
          report_mismatch("msg_id", 32'(msg_id_o), 32'(want.msg_id));
        if (payload_length_o !== want.payload_length)
          report_mismatch("payload_length", 32'(payload_length_o),
                          32'(want.payload_length));
      end
    end
  end

  initial begin
    result_t     typed_res;
    int unsigned frame_idx;
    frame_idx = 0;
    clear_frame_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      typed_res                = '0;
      typed_res.done           = 1'b1;
      typed_res.status         = DirectedRows[i].st;
      typed_res.msg_id         = DirectedRows[i].id;
      typed_res.payload_length = DirectedRows[i].plen;
      send_byte(DirectedRows[i].data, DirectedRows[i].lst, DirectedRows[i].typed, typed_res);
    end
    wait_drained();

    while (random_items < RandomItems) begin
      build_frame();
      random_items += frame_q.size();
      send_frame();
      frame_idx++;
      if (frame_idx % 40 == 0) wait_drained();
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'd0, 32'(pending_results.size()));
    if (mismatch_count == 0) begin
      $display("varint_frame_deframer_unit_test passed");
    end else begin
      $display("varint_frame_deframer_unit_test failed");
    end
    $finish;
  end

endmodule
